FILE: hdl/mrbr_pkg.sv
// Shared types and codes of the multi-reader broadcast ring.
package mrbr_pkg;

	// Operation codes
	localparam logic [1:0] OP_PUSH       = 2'd0;
	localparam logic [1:0] OP_POP        = 2'd1;
	localparam logic [1:0] OP_REGISTER   = 2'd2;
	localparam logic [1:0] OP_UNREGISTER = 2'd3;

	// Status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_OVERSIZE = 3'd3;
	localparam logic [2:0] ST_NOFREE   = 3'd4;

	// Configuration register indexes and port widths
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 9;
	localparam logic [CFG_INDEX_W-1:0] CFG_RING_ENTRIES      = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD_BYTES = 4'd1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  reader;
		logic        auto_pick;
		logic [63:0] payload;
		logic [3:0]  byte_count;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] read_payload;
		logic [3:0]  read_count;
		logic [2:0]  assigned_reader;
	} result_t;

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic item_load;
		logic commit;
		logic result_load;
	} cmd_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic is_pop;
	} stat_t;

endpackage

FILE: hdl/mrbr_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface mrbr_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/mrbr_cfg_if.sv
// Configuration write channel: register index and write data.
interface mrbr_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [mrbr_pkg::CFG_INDEX_W-1:0] index;
	logic [mrbr_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: hdl/mrbr_ctrl.sv
// Sequencer: accepts an item, commits it, and manages the result register.
module mrbr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output mrbr_pkg::cmd_t  cmd,
	input  mrbr_pkg::stat_t stat
);
	import mrbr_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_RDATA = 2'd2;

	logic [1:0] state_q, state_d;
	logic       out_valid_q, out_valid_d;
	logic       out_free;

	// Result register can take a new beat when empty or draining now
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d         = state_q;
		cmd.item_load   = 1'b0;
		cmd.commit      = 1'b0;
		cmd.result_load = 1'b0;
		out_valid_d     = out_valid_q && !out_ready;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					if (stat.is_pop) begin
						state_d = S_RDATA;
					end else begin
						out_valid_d = 1'b1;
						state_d     = S_IDLE;
					end
				end
			end
			S_RDATA: begin
				cmd.result_load = 1'b1;
				out_valid_d     = 1'b1;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

FILE: hdl/mrbr_datapath.sv
// Ring datapath: configuration, indices, reader flags, entry memory, result register.
module mrbr_datapath #(
	parameter int DEPTH      = 256,
	parameter int READERS    = 8,
	parameter int WORD_BYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	mrbr_cfg_if.sink          cfg,
	input  mrbr_pkg::item_t   item_data,
	input  mrbr_pkg::cmd_t    cmd,
	output mrbr_pkg::stat_t   stat,
	output mrbr_pkg::result_t result_data
);
	import mrbr_pkg::*;

	localparam int IW        = $clog2(DEPTH);
	localparam int NW        = $clog2(DEPTH + 1);
	localparam int RW        = (READERS > 1) ? $clog2(READERS) : 1;
	localparam int PW        = 8 * WORD_BYTES;
	localparam int RESET_N   = (DEPTH < 256) ? DEPTH : 256;
	localparam int RESET_LIM = (WORD_BYTES < 8) ? WORD_BYTES : 8;

	// Configuration
	logic [NW-1:0] ring_size_q, ring_wr;
	logic [3:0]    limit_q, limit_wr;

	// Ring state
	logic [IW-1:0]      wr_idx_q;
	logic [IW-1:0]      rd_idx_q [READERS];
	logic [READERS-1:0] active_q;

	// Entry memory
	logic [PW-1:0] mem_pay [DEPTH];
	logic [3:0]    mem_cnt [DEPTH];
	logic [PW-1:0] mem_pay_q;
	logic [3:0]    mem_cnt_q;

	// Held item and result
	item_t       item_q;
	logic [2:0]  res_status_q;
	logic [2:0]  res_assigned_q;
	logic [63:0] res_payload_q;
	logic [3:0]  res_count_q;
	logic        pop_hit_q;

	// Decode
	logic [IW-1:0] push_next, pop_next, reg_index;
	logic          full, oversize, rd_ok, pop_empty, free_found, chosen_ok;
	logic [RW-1:0] rsel, free_idx, chosen;
	logic [PW-1:0] masked;
	logic [2:0]    status;
	logic          push_ok, pop_ok, reg_ok, unreg_ok;

	function automatic logic [IW-1:0] next_of(logic [IW-1:0] i, logic [NW-1:0] n);
		logic [NW:0] s;
		s = (NW + 1)'(i) + (NW + 1)'(1);
		return (s >= (NW + 1)'(n)) ? '0 : IW'(s);
	endfunction

	function automatic logic [IW-1:0] prev_of(logic [IW-1:0] i, logic [NW-1:0] n);
		if (i == '0 || NW'(i) >= n) begin
			return IW'(n - NW'(1));
		end
		return i - IW'(1);
	endfunction

	// Clamp configuration write values
	always_comb begin
		if (cfg.data < 9'd2) begin
			ring_wr = NW'(2);
		end else if ({23'b0, cfg.data} > 32'(DEPTH)) begin
			ring_wr = NW'(DEPTH);
		end else begin
			ring_wr = NW'(cfg.data);
		end
		limit_wr = (cfg.data[3:0] > 4'(WORD_BYTES)) ? 4'(WORD_BYTES) : cfg.data[3:0];
	end

	assign cfg.ready = 1'b1;

	// Push checks: oversize, and any active reader sitting on the next write slot
	always_comb begin
		push_next = next_of(wr_idx_q, ring_size_q);
		oversize  = item_q.byte_count > limit_q;
		full      = 1'b0;
		for (int r = 0; r < READERS; r++) begin
			if (active_q[r] && rd_idx_q[r] == push_next) begin
				full = 1'b1;
			end
		end
	end

	// Pop checks
	assign rd_ok     = {29'b0, item_q.reader} < 32'(READERS);
	assign rsel      = RW'(item_q.reader);
	assign pop_next  = next_of(rd_idx_q[rsel], ring_size_q);
	assign pop_empty = !rd_ok || !active_q[rsel] || (pop_next == wr_idx_q);

	// Lowest-numbered inactive reader
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int r = READERS - 1; r >= 0; r--) begin
			if (!active_q[r]) begin
				free_found = 1'b1;
				free_idx   = RW'(r);
			end
		end
	end

	assign chosen    = item_q.auto_pick ? free_idx : rsel;
	assign chosen_ok = item_q.auto_pick ? free_found : rd_ok;
	assign reg_index = prev_of(wr_idx_q, ring_size_q);

	// Zero the bytes beyond the byte count
	always_comb begin
		for (int b = 0; b < WORD_BYTES; b++) begin
			masked[8*b +: 8] = (4'(b) < item_q.byte_count) ? item_q.payload[8*b +: 8] : 8'h00;
		end
	end

	// Operation outcome
	always_comb begin
		push_ok  = 1'b0;
		pop_ok   = 1'b0;
		reg_ok   = 1'b0;
		unreg_ok = 1'b0;
		status   = ST_OK;
		unique case (item_q.operation)
			OP_PUSH: begin
				if (oversize) begin
					status = ST_OVERSIZE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					push_ok = 1'b1;
				end
			end
			OP_POP: begin
				if (pop_empty) begin
					status = ST_EMPTY;
				end else begin
					pop_ok = 1'b1;
				end
			end
			OP_REGISTER: begin
				if (chosen_ok) begin
					reg_ok = 1'b1;
				end else begin
					status = ST_NOFREE;
				end
			end
			OP_UNREGISTER: begin
				unreg_ok = rd_ok;
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	assign stat.is_pop = (item_q.operation == OP_POP);

	// Configuration, indices and reader flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= NW'(RESET_N);
			limit_q     <= 4'(RESET_LIM);
			wr_idx_q    <= '0;
			active_q    <= '0;
			for (int r = 0; r < READERS; r++) begin
				rd_idx_q[r] <= '0;
			end
		end else begin
			if (cfg.valid && cfg.index == CFG_RING_ENTRIES) begin
				ring_size_q <= ring_wr;
			end
			if (cfg.valid && cfg.index == CFG_MAX_PAYLOAD_BYTES) begin
				limit_q <= limit_wr;
			end
			if (cmd.commit) begin
				if (push_ok) begin
					wr_idx_q <= push_next;
				end
				if (pop_ok) begin
					rd_idx_q[rsel] <= pop_next;
				end
				if (reg_ok) begin
					active_q[chosen] <= 1'b1;
					rd_idx_q[chosen] <= reg_index;
				end
				if (unreg_ok) begin
					active_q[rsel] <= 1'b0;
					rd_idx_q[rsel] <= wr_idx_q;
				end
			end
		end
	end

	// Entry memory: write on push, registered read on pop
	always_ff @(posedge clk) begin
		if (cmd.commit && push_ok) begin
			mem_pay[wr_idx_q] <= masked;
			mem_cnt[wr_idx_q] <= item_q.byte_count;
		end
		if (cmd.commit && pop_ok) begin
			mem_pay_q <= mem_pay[pop_next];
			mem_cnt_q <= mem_cnt[pop_next];
		end
	end

	// Hold the item and build the result beat
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			item_q <= item_data;
		end
		if (cmd.commit) begin
			res_status_q   <= status;
			res_assigned_q <= reg_ok ? 3'(chosen) : 3'd0;
			res_payload_q  <= '0;
			res_count_q    <= '0;
			pop_hit_q      <= pop_ok;
		end
		if (cmd.result_load) begin
			res_payload_q <= pop_hit_q ? 64'(mem_pay_q) : 64'd0;
			res_count_q   <= pop_hit_q ? mem_cnt_q : 4'd0;
		end
	end

	assign result_data.status          = res_status_q;
	assign result_data.read_payload    = res_payload_q;
	assign result_data.read_count      = res_count_q;
	assign result_data.assigned_reader = res_assigned_q;

endmodule

FILE: hdl/multi_reader_broadcast_ring_unit.sv
// Top level of the multi-reader broadcast ring: sequencer plus datapath.
//
//   channel   role    payload
//   item      sink    operation, reader, auto_pick, payload, byte_count
//   result    source  status, read_payload, read_count, assigned_reader
//   cfg       sink    index, data (ring_entries, max_payload_bytes)
//
// Each item is accepted in S_IDLE and commits in S_EXEC; a pop then passes S_RDATA,
// which loads the registered read of the entry memory into the result register.
// One item is in work at a time; the next is accepted once the current one's result
// is loaded, while that result may still wait in the output register.
// A stalled result holds commit of the following item until the output register frees.
// Async reset clears indices and reader flags, loads default config; entries stay undefined.
module multi_reader_broadcast_ring_unit #(
	parameter int DEPTH      = 256,
	parameter int READERS    = 8,
	parameter int WORD_BYTES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	mrbr_stream_if.sink  item,
	mrbr_stream_if.source result,
	mrbr_cfg_if.sink     cfg
);
	import mrbr_pkg::*;

	cmd_t    cmd;
	stat_t   stat;
	result_t result_data;

	mrbr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	mrbr_datapath #(
		.DEPTH      (DEPTH),
		.READERS    (READERS),
		.WORD_BYTES (WORD_BYTES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.item_data   (item.data),
		.cmd         (cmd),
		.stat        (stat),
		.result_data (result_data)
	);

	assign result.data = result_data;

endmodule

FILE: tb/sv/tb_multi_reader_broadcast_ring_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of the multi-reader broadcast ring with its own ring predictor.
module tb_multi_reader_broadcast_ring_unit;
	import mrbr_pkg::*;

	localparam int RING_DEPTH   = 256;
	localparam int RING_READERS = 8;
	localparam int RING_WORD    = 8;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 53;
	localparam int STALL_LIMIT  = 1000;
	localparam int LONG_HOLD    = 48;
	localparam int MAX_REPORTS  = 10;
	// index that decodes to no register; a write there must change nothing
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 4'hF;

	// Ring predictor plus the queue of results still owed by the block
	class ring_scoreboard;
		logic [8:0]  ring_cfg;
		logic [3:0]  byte_cfg;
		bit   [7:0]  wr_idx;
		bit   [7:0]  rd_idx [RING_READERS];
		bit          rd_on  [RING_READERS];
		logic [63:0] slot_data [RING_DEPTH];
		logic [3:0]  slot_len  [RING_DEPTH];
		bit          slot_seen [RING_DEPTH];
		result_t     awaited_results[$];
		int          fault_count;

		function new();
			ring_cfg = 9'd256;
			byte_cfg = 4'd8;
			wr_idx = '0;
			fault_count = 0;
			for (int r = 0; r < RING_READERS; r++) begin
				rd_idx[r] = '0;
				rd_on[r] = 1'b0;
			end
			for (int s = 0; s < RING_DEPTH; s++) begin
				slot_data[s] = '0;
				slot_len[s] = '0;
				slot_seen[s] = 1'b0;
			end
		endfunction

		function int unsigned ring_len();
			int unsigned n;
			n = ring_cfg;
			if (n < 2) n = 2;
			if (n > RING_DEPTH) n = RING_DEPTH;
			return n;
		endfunction

		function int unsigned step_fwd(int unsigned i);
			return (i + 1 >= ring_len()) ? 0 : i + 1;
		endfunction

		function int unsigned step_back(int unsigned i);
			return (i == 0 || i >= ring_len()) ? ring_len() - 1 : i - 1;
		endfunction

		function int unsigned byte_limit();
			return (byte_cfg > RING_WORD) ? RING_WORD : byte_cfg;
		endfunction

		function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_RING_ENTRIES) ring_cfg = val;
			else if (idx == CFG_MAX_PAYLOAD_BYTES) byte_cfg = val[3:0];
		endfunction

		// True when a pop by this reader would land on a slot never written
		function bit pop_hits_unwritten(int unsigned r);
			int unsigned nx;
			if (!rd_on[r]) return 1'b0;
			nx = step_fwd(rd_idx[r]);
			return nx != wr_idx && !slot_seen[nx];
		endfunction

		// Advance the ring by one accepted beat and queue the result it owes
		function void note_item(item_t it);
			result_t     res;
			int unsigned nx;
			int unsigned chosen;
			logic [63:0] kept;
			res = '0;
			res.status = ST_OK;
			case (it.operation)
				OP_PUSH: begin
					if (it.byte_count > byte_limit()) begin
						res.status = ST_OVERSIZE;
					end else begin
						nx = step_fwd(wr_idx);
						for (int r = 0; r < RING_READERS; r++)
							if (rd_on[r] && rd_idx[r] == nx) res.status = ST_FULL;
						if (res.status == ST_OK) begin
							kept = it.payload;
							if (it.byte_count < 8)
								kept = kept & ((64'd1 << (it.byte_count * 8)) - 64'd1);
							slot_data[wr_idx] = kept;
							slot_len[wr_idx] = it.byte_count;
							slot_seen[wr_idx] = 1'b1;
							wr_idx = 8'(nx);
						end
					end
				end
				OP_POP: begin
					if (!rd_on[it.reader]) begin
						res.status = ST_EMPTY;
					end else begin
						nx = step_fwd(rd_idx[it.reader]);
						if (nx == wr_idx) begin
							res.status = ST_EMPTY;
						end else begin
							res.read_payload = slot_data[nx];
							res.read_count = slot_len[nx];
							rd_idx[it.reader] = 8'(nx);
						end
					end
				end
				OP_REGISTER: begin
					chosen = RING_READERS;
					if (it.auto_pick) begin
						for (int r = RING_READERS - 1; r >= 0; r--)
							if (!rd_on[r]) chosen = r;
					end else begin
						chosen = it.reader;
					end
					if (chosen >= RING_READERS) begin
						res.status = ST_NOFREE;
					end else begin
						rd_on[chosen] = 1'b1;
						rd_idx[chosen] = 8'(step_back(wr_idx));
						res.assigned_reader = 3'(chosen);
					end
				end
				default: begin
					rd_on[it.reader] = 1'b0;
					rd_idx[it.reader] = wr_idx;
				end
			endcase
			awaited_results.insert(awaited_results.size(), res);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (awaited_results.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("unexpected result: status %0d payload %h count %0d reader %0d",
						got.status, got.read_payload, got.read_count, got.assigned_reader);
				return;
			end
			want = awaited_results.pop_front();
			if (got.status !== want.status || got.read_payload !== want.read_payload ||
			    got.read_count !== want.read_count ||
			    got.assigned_reader !== want.assigned_reader) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display({"mismatch: exp status %0d payload %h count %0d reader %0d, ",
						"got status %0d payload %h count %0d reader %0d"},
						want.status, want.read_payload, want.read_count, want.assigned_reader,
						got.status, got.read_payload, got.read_count, got.assigned_reader);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   gaps_on;
	bit   stalls_on;
	int   hold_asks;
	int   quiet_cycles;

	logic [CFG_DATA_W-1:0] phase_ring [PHASES] =
		'{9'd2, 9'd4, 9'd0, 9'd511, 9'd5, 9'd16, 9'd1, 9'd256};
	logic [CFG_DATA_W-1:0] phase_bytes [PHASES] =
		'{9'd1, 9'd15, 9'd0, 9'd8, 9'h1F3, 9'd8, 9'd7, 9'd8};

	ring_scoreboard sb = new();

	mrbr_stream_if #(.T(item_t))   item_bus ();
	mrbr_stream_if #(.T(result_t)) result_bus ();
	mrbr_cfg_if                    cfg_bus ();

	multi_reader_broadcast_ring_unit #(
		.DEPTH(RING_DEPTH),
		.READERS(RING_READERS),
		.WORD_BYTES(RING_WORD)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.result(result_bus),
		.cfg(cfg_bus)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic item_t make_item(logic [1:0] op, logic [2:0] rd, logic pick,
			logic [63:0] data, logic [3:0] cnt);
		item_t it;
		it.operation = op;
		it.reader = rd;
		it.auto_pick = pick;
		it.payload = data;
		it.byte_count = cnt;
		return it;
	endfunction

	// Mostly well-formed traffic: pops and unregisters aim at live readers
	function automatic item_t pick_item();
		item_t       it;
		int unsigned roll;
		int unsigned live[$];
		for (int r = 0; r < RING_READERS; r++)
			if (sb.rd_on[r]) live.insert(live.size(), r);
		it.reader = 3'($urandom_range(0, RING_READERS - 1));
		it.auto_pick = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 9);
		if (roll == 0) it.payload = '1;
		else if (roll == 1) it.payload = '0;
		else it.payload = {$urandom, $urandom};
		if ($urandom_range(0, 4) != 0) it.byte_count = 4'($urandom_range(0, sb.byte_limit()));
		else it.byte_count = 4'($urandom_range(0, 15));
		roll = $urandom_range(0, 99);
		if (roll < 40) it.operation = OP_PUSH;
		else if (roll < 75) it.operation = OP_POP;
		else if (roll < 90) it.operation = OP_REGISTER;
		else it.operation = OP_UNREGISTER;
		if ((it.operation == OP_POP || it.operation == OP_UNREGISTER) && live.size() != 0 &&
		    $urandom_range(0, 9) < 8)
			it.reader = 3'(live[$urandom_range(0, live.size() - 1)]);
		// steer away from slots never written since reset
		if (it.operation == OP_POP && sb.pop_hits_unwritten(it.reader))
			it.operation = OP_PUSH;
		return it;
	endfunction

	// Offer one beat, with an optional idle burst first, and note it once taken
	task automatic send_item(input item_t it);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.data <= it;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		sb.note_item(it);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		sb.note_config(idx, val);
	endtask

	// Drain the block, let it settle, then load a new setting
	task automatic set_phase(input int p);
		item_bus.valid <= 1'b0;
		while (sb.awaited_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		write_reg(CFG_RING_ENTRIES, phase_ring[p]);
		write_reg(CFG_MAX_PAYLOAD_BYTES, phase_bytes[p]);
		if (p == 3) write_reg(CFG_UNUSED_INDEX, 9'h1FF);
		cfg_bus.valid <= 1'b0;
	endtask

	// Result side: random stall bursts, plus a long hold-off on request
	initial begin
		int hold_served;
		hold_served = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_served) begin
				hold_served = hold_asks;
				result_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (stalls_on && $urandom_range(0, 3) == 0) begin
				result_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
		end
	end

	// Check every beat taken from the result channel
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			sb.check_result(result_bus.data);
	end

	// End the run when no channel has moved a beat for too long
	always @(posedge clk) begin
		if (!arst_n || (item_bus.valid && item_bus.ready) ||
		    (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.data = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty and inactive readers, byte limits, registration corners
		send_item(make_item(OP_POP, 3'd0, 1'b0, '0, 4'd0));
		send_item(make_item(OP_UNREGISTER, 3'd7, 1'b0, '0, 4'd0));
		send_item(make_item(OP_REGISTER, 3'd5, 1'b1, '0, 4'd0));
		send_item(make_item(OP_POP, 3'd0, 1'b0, '0, 4'd0));
		send_item(make_item(OP_PUSH, 3'd0, 1'b0, '1, 4'd8));
		send_item(make_item(OP_PUSH, 3'd7, 1'b1, '0, 4'd0));
		send_item(make_item(OP_PUSH, 3'd0, 1'b0, 64'hA5A5_5A5A_0F0F_F0F0, 4'd9));
		send_item(make_item(OP_PUSH, 3'd0, 1'b0, '1, 4'd15));
		send_item(make_item(OP_PUSH, 3'd0, 1'b0, 64'h0123_4567_89AB_CDEF, 4'd3));
		repeat (3) send_item(make_item(OP_POP, 3'd0, 1'b0, '0, 4'd0));
		send_item(make_item(OP_POP, 3'd0, 1'b0, '0, 4'd0));
		send_item(make_item(OP_REGISTER, 3'd7, 1'b0, '0, 4'd0));
		send_item(make_item(OP_REGISTER, 3'd0, 1'b0, '0, 4'd0));
		// fill the remaining readers, then one more auto pick finds none free
		repeat (7) send_item(make_item(OP_REGISTER, 3'd2, 1'b1, '0, 4'd0));
		send_item(make_item(OP_UNREGISTER, 3'd3, 1'b0, '0, 4'd0));
		send_item(make_item(OP_REGISTER, 3'd6, 1'b1, '0, 4'd0));

		// Random phases over the setting list; the last one runs without idling
		for (int p = 0; p < PHASES; p++) begin
			set_phase(p);
			if (p == 1 || p == 5) hold_asks++;
			if (p == PHASES - 1) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			repeat (PHASE_ITEMS) send_item(pick_item());
		end

		item_bus.valid <= 1'b0;
		while (sb.awaited_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.fault_count == 0 && sb.awaited_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
